[sv/stb_pkg.sv]
// ----------------------------------------------------------------------------
// Software timer bank package
// Shared constants, codes and types for the timer bank and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int SCAN_W = $clog2(NUM_TIMERS) + 1;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic        start;
    logic        stop;
    logic [31:0] timeout;
    logic        mode;
  } wr_t;

endpackage

`default_nettype wire

[sv/stb_cell.sv]
// ----------------------------------------------------------------------------
// Timer cell
// Holds one timer and checks it when the scan token passes through.
// ----------------------------------------------------------------------------
`default_nettype none

module stb_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [31:0]   tick_count,
  input  wire logic          sel,
  input  wire stb_pkg::wr_t  wr,
  input  wire logic          token_in,
  output logic               token_out,
  output logic               fire
);

  logic [31:0] start_time;
  logic [31:0] timeout_ticks;
  logic        periodic;
  logic [31:0] elapsed;

  assign elapsed = tick_count - start_time;
  assign fire = token_in && (timeout_ticks != 32'd0) && (elapsed >= timeout_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time    <= 32'd0;
      timeout_ticks <= 32'd0;
      periodic      <= 1'b0;
      token_out     <= 1'b0;
    end else begin
      token_out <= token_in;
      if (sel && wr.start) begin
        timeout_ticks <= wr.timeout;
        periodic      <= wr.mode;
        start_time    <= tick_count;
      end else if (sel && wr.stop) begin
        timeout_ticks <= 32'd0;
      end else if (fire) begin
        if (periodic) begin
          start_time <= tick_count;
        end else begin
          timeout_ticks <= 32'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/software_timer_bank.sv]
// ----------------------------------------------------------------------------
// Software timer bank
// A row of timer cells checked in index order by a token on every tick.
// ----------------------------------------------------------------------------
// An item is accepted when start is high and busy is low. func selects a
// tick, a timer start or a timer stop. Start and stop leave busy low. A
// tick advances the 32-bit count and launches a scan token down the row
// of cells, one cell per cycle. Each timer that has expired gives one
// item on expired_timer, marked by a one-cycle strobe; last marks the
// final item of the tick. Items are held back one firing so that last
// can be set, and the final one leaves in the cycle after the token
// passes the last cell. A tick keeps busy high until the token has left
// the last cell, so no new tick is taken before its scan ends; the
// spacing is set by the token walking the chain of cells.
// The strobe is registered and the receiver cannot stall it.
// Reset clears the count and disables every timer.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_bank (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic [2:0]  timer_index,
  input  wire logic [31:0] timeout,
  input  wire logic        mode,
  output logic             strobe,
  output logic [2:0]       expired_timer,
  output logic             last
);

  stb_pkg::state_t                state;
  stb_pkg::state_t                state_next;
  logic [31:0]                    tick_count;
  logic                           launch;
  logic [stb_pkg::SCAN_W-1:0]     scan_idx;
  logic                           pend_valid;
  logic [2:0]                     pend_idx;
  logic                           accept;
  logic                           tick_go;
  stb_pkg::wr_t                   wr;
  logic [stb_pkg::NUM_TIMERS:0]   token;
  logic [stb_pkg::NUM_TIMERS-1:0] fire_vec;
  logic                           any_fire;
  logic                           scan_end;

  assign busy    = (state != stb_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign tick_go = accept && (func == stb_pkg::FUNC_TICK);

  assign wr.start   = accept && (func == stb_pkg::FUNC_START);
  assign wr.stop    = accept && (func == stb_pkg::FUNC_STOP);
  assign wr.timeout = timeout;
  assign wr.mode    = mode;

  assign token[0] = launch;

  for (genvar i = 0; i < stb_pkg::NUM_TIMERS; i++) begin : g_cell
    stb_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .tick_count (tick_count),
      .sel        (32'(timer_index) == i),
      .wr         (wr),
      .token_in   (token[i]),
      .token_out  (token[i+1]),
      .fire       (fire_vec[i])
    );
  end

  assign any_fire = |fire_vec;
  assign scan_end = token[stb_pkg::NUM_TIMERS];

  always_comb begin
    state_next = state;
    unique case (state)
      stb_pkg::ST_IDLE: begin
        if (tick_go) begin
          state_next = stb_pkg::ST_SCAN;
        end
      end
      stb_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = stb_pkg::ST_IDLE;
        end
      end
      default: state_next = stb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= stb_pkg::ST_IDLE;
      tick_count <= 32'd0;
      launch     <= 1'b0;
      scan_idx   <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= tick_go;
      strobe <= 1'b0;
      if (tick_go) begin
        tick_count <= tick_count + 32'd1;
        scan_idx   <= '0;
      end else if (state == stb_pkg::ST_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (state == stb_pkg::ST_SCAN) begin
        if (any_fire) begin
          strobe     <= pend_valid;
          pend_valid <= 1'b1;
        end else if (scan_end) begin
          strobe     <= pend_valid;
          pend_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == stb_pkg::ST_SCAN && (any_fire || scan_end)) begin
      expired_timer <= pend_idx;
      last          <= scan_end;
    end
    if (state == stb_pkg::ST_SCAN && any_fire) begin
      pend_idx <= 3'(scan_idx);
    end
  end

  a_fire_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(fire_vec))
    else $error("More than one timer cell fired in the same cycle.");

  a_fire_in_scan: assert property (@(posedge clk) disable iff (rst)
    any_fire |-> state == stb_pkg::ST_SCAN)
    else $error("A timer cell fired outside a scan.");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (state == stb_pkg::ST_SCAN && scan_end) |=> state == stb_pkg::ST_IDLE)
    else $error("The scan did not finish when the token left the row.");

  a_tick_adv: assert property (@(posedge clk) disable iff (rst)
    tick_go |=> tick_count == $past(tick_count) + 32'd1)
    else $error("The tick count did not advance on a tick item.");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !pend_valid && state == stb_pkg::ST_IDLE)
    else $error("The final item of a tick left with work still pending.");

endmodule

`default_nettype wire

[sim/software_timer_bank_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer bank testbench
// Drives start, stop, tick and unused commands into the timer bank and checks
// every expiry item against a cycle-free model of the timer state kept here.
// A directed opening covers zero, one and all-ones timeouts, both modes, all
// timers firing on one tick, stop, and the unused function code. Random
// commands follow over four pacing phases, each opened by a drain.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_bank_tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_CMDS_PER_PHASE = 58;

  typedef struct {
    logic [1:0]  code;
    logic [2:0]  idx;
    logic [31:0] tmo;
    logic        periodic;
    int          idle_pct;
    bit          drain;
  } timer_cmd_t;

  typedef struct {
    logic [2:0] timer;
    logic       last;
  } expiry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func = stb_pkg::FUNC_TICK;
  logic [2:0]  timer_index = 3'd0;
  logic [31:0] timeout = 32'd0;
  logic        mode = 1'b0;
  logic        strobe;
  logic [2:0]  expired_timer;
  logic        last;

  timer_cmd_t cmd_q[$];
  expiry_t    pending_expiries[$];

  logic [31:0] tick_now;
  logic [31:0] timer_base[stb_pkg::NUM_TIMERS];
  logic [31:0] timer_len[stb_pkg::NUM_TIMERS];
  logic        timer_periodic[stb_pkg::NUM_TIMERS];

  bit cmd_taken = 1'b0;
  int quiet_cycles = 0;
  int error_count = 0;
  int cmds_taken = 0;
  int ticks_taken = 0;
  int expiries_seen = 0;
  int multi_fire_ticks = 0;

  software_timer_bank i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .timer_index   (timer_index),
    .timeout       (timeout),
    .mode          (mode),
    .strobe        (strobe),
    .expired_timer (expired_timer),
    .last          (last)
  );

  always #5 clk = ~clk;

  task automatic queue_cmd(input logic [1:0] code, input logic [2:0] idx,
                           input logic [31:0] tmo, input logic periodic,
                           input int idle_pct, input bit drain);
    timer_cmd_t c;
    c.code = code;
    c.idx = idx;
    c.tmo = tmo;
    c.periodic = periodic;
    c.idle_pct = idle_pct;
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  task automatic predict_expiries(input logic [1:0] code, input logic [2:0] idx,
                                  input logic [31:0] tmo, input logic periodic);
    logic [2:0]  fired[$];
    logic [31:0] elapsed;
    expiry_t     e;
    case (code)
      stb_pkg::FUNC_START: begin
        timer_len[idx] = tmo;
        timer_periodic[idx] = periodic;
        timer_base[idx] = tick_now;
      end
      stb_pkg::FUNC_STOP: begin
        timer_len[idx] = 32'd0;
      end
      stb_pkg::FUNC_TICK: begin
        tick_now = tick_now + 32'd1;
        for (int t = 0; t < stb_pkg::NUM_TIMERS; t++) begin
          elapsed = tick_now - timer_base[t];
          if (timer_len[t] != 32'd0 && elapsed >= timer_len[t]) begin
            if (timer_periodic[t]) begin
              timer_base[t] = tick_now;
            end else begin
              timer_len[t] = 32'd0;
            end
            fired.push_back(t[2:0]);
          end
        end
        if (fired.size() > 1) multi_fire_ticks++;
        for (int k = 0; k < fired.size(); k++) begin
          e.timer = fired[k];
          e.last = (k == fired.size() - 1);
          pending_expiries.push_back(e);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(negedge clk) begin : drive
    timer_cmd_t next_cmd;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || cmd_taken) begin
      if (cmd_q.size() > 0 && !(cmd_q[0].drain && pending_expiries.size() != 0) &&
          $urandom_range(99) >= cmd_q[0].idle_pct) begin
        next_cmd = cmd_q.pop_front();
        start <= 1'b1;
        func <= next_cmd.code;
        timer_index <= next_cmd.idx;
        timeout <= next_cmd.tmo;
        mode <= next_cmd.periodic;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : observe
    expiry_t want;
    cmd_taken = 1'b0;
    if (!rst) begin
      quiet_cycles++;
      if (strobe) begin
        quiet_cycles = 0;
        expiries_seen++;
        if (pending_expiries.size() == 0) begin
          $error("expired_timer: no item expected, got %0d (last %0d)",
                 expired_timer, last);
          error_count++;
        end else begin
          want = pending_expiries.pop_front();
          if (expired_timer !== want.timer) begin
            $error("expired_timer: expected %0d, got %0d", want.timer, expired_timer);
            error_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        cmd_taken = 1'b1;
        quiet_cycles = 0;
        cmds_taken++;
        if (func == stb_pkg::FUNC_TICK) ticks_taken++;
        predict_expiries(func, timer_index, timeout, mode);
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("software_timer_bank_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int phase_idle[4];
    int counted;
    int r;
    int pick;
    logic [31:0] tmo;

    phase_idle = '{0, 76, 0, 28};
    tick_now = 32'd0;
    for (int t = 0; t < stb_pkg::NUM_TIMERS; t++) begin
      timer_base[t] = 32'd0;
      timer_len[t] = 32'd0;
      timer_periodic[t] = 1'b0;
    end

    queue_cmd(stb_pkg::FUNC_TICK, 3'd0, 32'd0, 1'b0, 0, 1'b0);
    queue_cmd(FUNC_UNUSED, 3'd7, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
    queue_cmd(stb_pkg::FUNC_START, 3'd0, 32'd1, 1'b0, 0, 1'b0);
    queue_cmd(stb_pkg::FUNC_START, 3'd7, 32'd1, 1'b1, 0, 1'b0);
    queue_cmd(stb_pkg::FUNC_START, 3'd3, 32'd0, 1'b1, 0, 1'b0);
    queue_cmd(stb_pkg::FUNC_START, 3'd5, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
    queue_cmd(stb_pkg::FUNC_TICK, 3'd0, 32'd0, 1'b0, 0, 1'b0);
    queue_cmd(stb_pkg::FUNC_TICK, 3'd0, 32'd0, 1'b0, 0, 1'b0);
    queue_cmd(stb_pkg::FUNC_STOP, 3'd7, 32'd0, 1'b0, 0, 1'b0);
    queue_cmd(stb_pkg::FUNC_TICK, 3'd0, 32'd0, 1'b0, 0, 1'b0);
    for (int t = 0; t < stb_pkg::NUM_TIMERS; t++) begin
      queue_cmd(stb_pkg::FUNC_START, t[2:0], 32'd1, 1'b1, 0, 1'b0);
    end
    queue_cmd(stb_pkg::FUNC_TICK, 3'd0, 32'd0, 1'b0, 0, 1'b0);
    queue_cmd(stb_pkg::FUNC_STOP, 3'd2, 32'd0, 1'b0, 0, 1'b0);
    queue_cmd(stb_pkg::FUNC_TICK, 3'd5, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
    queue_cmd(FUNC_UNUSED, 3'd0, 32'd0, 1'b0, 0, 1'b0);

    for (int p = 0; p < 4; p++) begin
      counted = 0;
      while (counted < RANDOM_CMDS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 50) begin
          queue_cmd(stb_pkg::FUNC_TICK, 3'($urandom_range(7)), $urandom,
                    1'($urandom_range(1)), phase_idle[p], counted == 0);
          counted++;
        end else if (r < 78) begin
          pick = $urandom_range(9);
          if (pick == 0) tmo = 32'd0;
          else if (pick == 1) tmo = $urandom;
          else if (pick == 2) tmo = 32'hFFFF_FFFF;
          else tmo = $urandom_range(6, 1);
          queue_cmd(stb_pkg::FUNC_START, 3'($urandom_range(7)), tmo,
                    1'($urandom_range(1)), phase_idle[p], counted == 0);
          counted++;
        end else if (r < 93) begin
          queue_cmd(stb_pkg::FUNC_STOP, 3'($urandom_range(7)), $urandom,
                    1'($urandom_range(1)), phase_idle[p], counted == 0);
          counted++;
        end else begin
          queue_cmd(FUNC_UNUSED, 3'($urandom_range(7)), $urandom,
                    1'($urandom_range(1)), phase_idle[p], 1'b0);
        end
      end
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || start) @(posedge clk);
    while (pending_expiries.size() != 0) @(posedge clk);
    repeat (stb_pkg::NUM_TIMERS + 4) @(posedge clk);

    $display("Run covered %0d commands, %0d of them ticks, over four pacing phases.",
             cmds_taken, ticks_taken);
    $display("It checked %0d expiry items; %0d ticks fired more than one timer.",
             expiries_seen, multi_fire_ticks);
    if (error_count == 0) begin
      $display("software_timer_bank_tb: clean");
    end else begin
      $display("software_timer_bank_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
